// File: rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: scalar Kalman filter shared definitions
// Widths, register codes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int NOISE_W   = 16;

  localparam int EST_W   = SAMPLE_W + FRAC_BITS;      // estimate, QSW.F signed
  localparam int VAR_W   = SAMPLE_W + 2 + FRAC_BITS;  // variance, Q(SW+2).F
  localparam int GAIN_W  = FRAC_BITS + 1;             // gain, 0 .. 1.0
  localparam int SHIFT_W = NOISE_W + FRAC_BITS;       // noise term in fixed point
  localparam int ADD_W   = ((VAR_W > SHIFT_W) ? VAR_W : SHIFT_W) + 1;
  localparam int DQ_W    = SAMPLE_W + 1;              // integer part of z - x
  localparam int MUL_W   = ((FRAC_BITS + 2) > (SAMPLE_W + 3)) ? (FRAC_BITS + 2)
                                                           : (SAMPLE_W + 3);
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DX_W    = EST_W + 2;                 // estimate correction
  localparam int CNT_W   = $clog2(GAIN_W);
  localparam int MUL_STEPS = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (SAMPLE_W > NOISE_W) ? SAMPLE_W : NOISE_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE = CFG_IDX_W'(3);

  localparam logic [NOISE_W-1:0]  PROCESS_NOISE_RST    = NOISE_W'(200);
  localparam logic [NOISE_W-1:0]  MEASURE_NOISE_RST    = NOISE_W'(500);
  localparam logic [SAMPLE_W-1:0] INITIAL_ESTIMATE_RST = '0;
  localparam logic [NOISE_W-1:0]  INITIAL_VARIANCE_RST = '0;

  // multiply sequence, one product per cycle
  localparam logic [1:0] MUL_G_DQ  = 2'd0;  // gain * integer part of z - x
  localparam logic [1:0] MUL_G_DR  = 2'd1;  // gain * fraction part of z - x
  localparam logic [1:0] MUL_M_PHI = 2'd2;  // (1 - gain) * integer part of p
  localparam logic [1:0] MUL_M_PLO = 2'd3;  // (1 - gain) * fraction part of p

  typedef struct packed {
    logic [NOISE_W-1:0]  process_noise;
    logic [NOISE_W-1:0]  measure_noise;
    logic [SAMPLE_W-1:0] initial_estimate;
    logic [NOISE_W-1:0]  initial_variance;
  } cfg_regs_t;

  typedef struct packed {
    logic       capture;    // latch the accepted sample
    logic       predict;    // p + q, z - x
    logic       den_init;   // denominator and divider start
    logic       div_step;   // one quotient bit
    logic       div_first;  // integer bit: no shift
    logic       mul_en;     // one multiply step
    logic [1:0] mul_step;
    logic       commit;     // write state and result register
  } cmd_t;

  typedef struct packed {
    logic out_free;         // result register can take a new value
  } status_t;

endpackage

// File: rtl/core/skf_cfg.sv
// ----------------------------------------------------------------------------
// skf_cfg: configuration registers
// Four write-only registers; flags a state reload after an initial-value write.
// ----------------------------------------------------------------------------
module skf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [skf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output skf_pkg::cfg_regs_t               regs_o,
  output logic                             reload_o
);

  skf_pkg::cfg_regs_t regs_q, regs_d;
  logic               reload_q, reload_d;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    regs_d   = regs_q;
    reload_d = 1'b0;
    if (wr) begin
      unique case (cfg_index_i)
        skf_pkg::REG_PROCESS_NOISE: begin
          regs_d.process_noise = cfg_data_i[skf_pkg::NOISE_W-1:0];
        end
        skf_pkg::REG_MEASURE_NOISE: begin
          regs_d.measure_noise = cfg_data_i[skf_pkg::NOISE_W-1:0];
        end
        skf_pkg::REG_INITIAL_ESTIMATE: begin
          regs_d.initial_estimate = cfg_data_i[skf_pkg::SAMPLE_W-1:0];
          reload_d                = 1'b1;
        end
        skf_pkg::REG_INITIAL_VARIANCE: begin
          regs_d.initial_variance = cfg_data_i[skf_pkg::NOISE_W-1:0];
          reload_d                = 1'b1;
        end
        default: begin
          // unmapped index, ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.process_noise    <= skf_pkg::PROCESS_NOISE_RST;
      regs_q.measure_noise    <= skf_pkg::MEASURE_NOISE_RST;
      regs_q.initial_estimate <= skf_pkg::INITIAL_ESTIMATE_RST;
      regs_q.initial_variance <= skf_pkg::INITIAL_VARIANCE_RST;
      reload_q                <= 1'b0;
    end else begin
      regs_q   <= regs_d;
      reload_q <= reload_d;
    end
  end

  assign regs_o   = regs_q;
  assign reload_o = reload_q;

endmodule

// File: rtl/core/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl: filter sequencer
// Steps one sample through predict, gain division, multiplies and commit.
// ----------------------------------------------------------------------------
module skf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sample_valid_i,
  output logic             sample_stall_o,
  input  skf_pkg::status_t status_i,
  output skf_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRED = 3'd1;
  localparam logic [2:0] S_DEN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [skf_pkg::CNT_W-1:0] DIV_LAST = skf_pkg::CNT_W'(skf_pkg::GAIN_W - 1);
  localparam logic [skf_pkg::CNT_W-1:0] MUL_LAST = skf_pkg::CNT_W'(skf_pkg::MUL_STEPS - 1);

  logic [2:0]                state_q, state_d;
  logic [skf_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    sample_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        sample_stall_o = 1'b0;
        if (sample_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PRED;
        end
      end
      S_PRED: begin
        cmd_o.predict = 1'b1;
        state_d       = S_DEN;
      end
      S_DEN: begin
        cmd_o.den_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = cnt_q[1:0];
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/core/skf_dp.sv
// ----------------------------------------------------------------------------
// skf_dp: filter datapath
// State registers, predict adder, restoring divider, shared multiplier, result.
// ----------------------------------------------------------------------------
module skf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [skf_pkg::SAMPLE_W-1:0]  sample_i,
  input  skf_pkg::cfg_regs_t                   regs_i,
  input  logic                                 reload_i,
  input  skf_pkg::cmd_t                        cmd_i,
  output skf_pkg::status_t                     status_o,
  output logic                                 estimate_valid_o,
  input  logic                                 estimate_stall_i,
  output logic signed [skf_pkg::EST_W-1:0]     estimate_o
);

  localparam int LOAD_W = ((skf_pkg::NOISE_W + skf_pkg::FRAC_BITS) > skf_pkg::VAR_W)
                          ? (skf_pkg::NOISE_W + skf_pkg::FRAC_BITS) : skf_pkg::VAR_W;
  localparam logic [skf_pkg::VAR_W-1:0] VAR_MAX = '1;

  // filter state
  logic signed [skf_pkg::EST_W-1:0]  x_q, x_d;
  logic [skf_pkg::VAR_W-1:0]         p_q, p_d;
  // per-sample working registers
  logic signed [skf_pkg::SAMPLE_W-1:0] z_q;
  logic [skf_pkg::VAR_W-1:0]         pp_q;
  logic signed [skf_pkg::DQ_W-1:0]   dq_q;
  logic [skf_pkg::FRAC_BITS-1:0]     dr_q;
  logic [skf_pkg::ADD_W-1:0]         den_q, rem_q, rem_d;
  logic [skf_pkg::GAIN_W-1:0]        g_q, g_d;
  logic signed [skf_pkg::PROD_W-1:0] prod_q, t1_q, prod_d;
  logic signed [skf_pkg::DX_W-1:0]   dx_q;
  // result register
  logic                              out_valid_q;
  logic signed [skf_pkg::EST_W-1:0]  out_q;

  // initial-value load
  logic [LOAD_W-1:0]                 init_p;
  logic [skf_pkg::VAR_W-1:0]         init_p_sat;
  logic signed [skf_pkg::EST_W-1:0]  init_x;

  always_comb begin
    init_p     = LOAD_W'(regs_i.initial_variance) << skf_pkg::FRAC_BITS;
    init_p_sat = (init_p > LOAD_W'(VAR_MAX)) ? VAR_MAX : init_p[skf_pkg::VAR_W-1:0];
    init_x     = {signed'(regs_i.initial_estimate), {skf_pkg::FRAC_BITS{1'b0}}};
  end

  // predict: saturated p + q, and z - x split at the binary point
  logic [skf_pkg::ADD_W-1:0]          p_sum;
  logic [skf_pkg::VAR_W-1:0]          p_pred;
  logic signed [skf_pkg::EST_W:0]     diff;

  always_comb begin
    p_sum  = skf_pkg::ADD_W'(p_q)
           + (skf_pkg::ADD_W'(regs_i.process_noise) << skf_pkg::FRAC_BITS);
    p_pred = (p_sum > skf_pkg::ADD_W'(VAR_MAX)) ? VAR_MAX : p_sum[skf_pkg::VAR_W-1:0];
    diff   = {z_q[skf_pkg::SAMPLE_W-1], z_q, {skf_pkg::FRAC_BITS{1'b0}}}
           - {x_q[skf_pkg::EST_W-1], x_q};
  end

  // restoring divider, one quotient bit per cycle
  logic [skf_pkg::ADD_W:0] rem_sh;
  logic                    qbit;

  always_comb begin
    rem_sh = cmd_i.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
    qbit   = (rem_sh >= {1'b0, den_q}) && (den_q != '0);
    rem_d  = qbit ? skf_pkg::ADD_W'(rem_sh - {1'b0, den_q}) : rem_sh[skf_pkg::ADD_W-1:0];
    g_d    = {g_q[skf_pkg::GAIN_W-2:0], qbit};
  end

  // shared multiplier
  logic [skf_pkg::GAIN_W-1:0]        m_gain;
  logic signed [skf_pkg::MUL_W-1:0]  mul_a, mul_b;

  always_comb begin
    m_gain = skf_pkg::GAIN_W'(1 << skf_pkg::FRAC_BITS) - g_q;
    unique case (cmd_i.mul_step)
      skf_pkg::MUL_G_DQ: begin
        mul_a = signed'(skf_pkg::MUL_W'(g_q));
        mul_b = skf_pkg::MUL_W'(dq_q);
      end
      skf_pkg::MUL_G_DR: begin
        mul_a = signed'(skf_pkg::MUL_W'(g_q));
        mul_b = signed'(skf_pkg::MUL_W'(dr_q));
      end
      skf_pkg::MUL_M_PHI: begin
        mul_a = signed'(skf_pkg::MUL_W'(m_gain));
        mul_b = signed'(skf_pkg::MUL_W'(pp_q[skf_pkg::VAR_W-1:skf_pkg::FRAC_BITS]));
      end
      skf_pkg::MUL_M_PLO: begin
        mul_a = signed'(skf_pkg::MUL_W'(m_gain));
        mul_b = signed'(skf_pkg::MUL_W'(pp_q[skf_pkg::FRAC_BITS-1:0]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);
  end

  // commit values
  logic signed [skf_pkg::PROD_W-1:0] p_new;

  always_comb begin
    x_d   = x_q;
    p_d   = p_q;
    p_new = t1_q + (prod_q >>> skf_pkg::FRAC_BITS);
    if (reload_i) begin
      x_d = init_x;
      p_d = init_p_sat;
    end else if (cmd_i.commit) begin
      x_d = x_q + dx_q[skf_pkg::EST_W-1:0];
      p_d = p_new[skf_pkg::VAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      x_q <= x_d;
      p_q <= p_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!estimate_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      z_q <= sample_i;
    end
    if (cmd_i.predict) begin
      pp_q <= p_pred;
      dq_q <= diff[skf_pkg::EST_W:skf_pkg::FRAC_BITS];
      dr_q <= diff[skf_pkg::FRAC_BITS-1:0];
    end
    if (cmd_i.den_init) begin
      den_q <= skf_pkg::ADD_W'(pp_q)
             + (skf_pkg::ADD_W'(regs_i.measure_noise) << skf_pkg::FRAC_BITS);
      rem_q <= skf_pkg::ADD_W'(pp_q);
      g_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      g_q   <= g_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      unique case (cmd_i.mul_step)
        skf_pkg::MUL_G_DR: begin
          t1_q <= prod_q;                                  // gain * dq
        end
        skf_pkg::MUL_M_PHI: begin
          dx_q <= t1_q[skf_pkg::DX_W-1:0]
                + skf_pkg::DX_W'(prod_q >>> skf_pkg::FRAC_BITS);  // + floor(gain*dr)
        end
        skf_pkg::MUL_M_PLO: begin
          t1_q <= prod_q;                                  // (1 - gain) * p_hi
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.commit) begin
      out_q <= x_d;
    end
  end

  assign status_o.out_free = !out_valid_q || !estimate_stall_i;
  assign estimate_valid_o  = out_valid_q;
  assign estimate_o        = out_q;

endmodule

// File: rtl/core/scalar_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: 1-D Kalman smoother for signed sensor samples
// Fixed-point filter with unit state and measurement gains, one result/sample.
// ----------------------------------------------------------------------------
// One result per sample. A sample is taken when sample_valid_i is high and
// sample_stall_o low; the block then stalls its input while it predicts
// p + q, forms p + r, divides for the Q1.16 gain one bit per cycle, runs
// four products through one shared 19x19 multiplier and commits once the
// result register is free. The divider is the longest of these steps.
// The result sits in an output register, so the next sample is accepted
// while it waits on estimate_stall_i. The estimate is signed Q16.16, the
// variance Q18.16 saturating at its top. Config writes (index 0..3: process
// noise, measure noise, initial estimate, initial variance) are always
// ready; writing either initial value reloads both state registers. Higher
// indexes are ignored. Write config only while no sample is in flight.
module scalar_kalman_filter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample requests
  input  logic                                sample_valid_i,
  output logic                                sample_stall_o,
  input  logic signed [skf_pkg::SAMPLE_W-1:0] sample_i,
  // estimate requests
  output logic                                estimate_valid_o,
  input  logic                                estimate_stall_i,
  output logic signed [skf_pkg::EST_W-1:0]    estimate_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [skf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  skf_pkg::cfg_regs_t regs;
  logic               reload;
  skf_pkg::cmd_t      cmd;
  skf_pkg::status_t   status;

  skf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .regs_o      (regs),
    .reload_o    (reload)
  );

  // sequencer: owns the input handshake and the step order
  skf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // datapath: filter state, divider, multiplier, output register
  skf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (sample_i),
    .regs_i           (regs),
    .reload_i         (reload),
    .cmd_i            (cmd),
    .status_o         (status),
    .estimate_valid_o (estimate_valid_o),
    .estimate_stall_i (estimate_stall_i),
    .estimate_o       (estimate_o)
  );

endmodule
